### rtl/btrb_pkg.sv
// Shared types, codes and constants for the branch trace ring buffer.
// No dependencies; imported by every module of the block.
`default_nettype none

package btrb_pkg;

   // default ring depth handed to the top-level parameter
   localparam int TRACE_DEPTH_DEFAULT = 64;

   localparam int ADDR_BITS  = 16;
   localparam int COUNT_BITS = 32;
   localparam int POS_BITS   = 6;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = 32'hFFFF_FFFF;

   // command codes on the request channel
   localparam logic [1:0] CMD_RECORD = 2'd0;
   localparam logic [1:0] CMD_READ   = 2'd1;
   localparam logic [1:0] CMD_CLEAR  = 2'd2;

   // interrupt vector addresses
   localparam logic [ADDR_BITS-1:0] VEC_RESET = 16'hFFFC;
   localparam logic [ADDR_BITS-1:0] VEC_NMI   = 16'hFFFA;
   localparam logic [ADDR_BITS-1:0] VEC_IRQ   = 16'hFFFE;

   // vector kind codes on the response channel
   localparam logic [1:0] KIND_NONE  = 2'd0;
   localparam logic [1:0] KIND_RESET = 2'd1;
   localparam logic [1:0] KIND_NMI   = 2'd2;
   localparam logic [1:0] KIND_IRQ   = 2'd3;

   // one ring entry as held in the trace memory
   typedef struct packed {
      logic                  valid;
      logic [ADDR_BITS-1:0]  from_addr;
      logic [ADDR_BITS-1:0]  to_addr;
      logic [ADDR_BITS-1:0]  vector_addr;
      logic [COUNT_BITS-1:0] count;
   } entry_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RECORD,
      ST_REDUCE,
      ST_FETCH,
      ST_RESPOND
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;      // latch the accepted item, start slot sum
      logic clear_start;  // rewind pointer, drop newest-entry cache
      logic clear_step;   // zero one memory row
      logic record;       // merge or append the latched branch
      logic reduce;       // take one wrap off the slot number
      logic fetch;        // read the slot from memory
      logic load_rsp;     // move fetched entry into the response register
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic trace_enable;
      logic slot_in_range;
      logic clear_last;
      logic rsp_free;
   } dp_status_type;

   function automatic logic [1:0] decode_vector(input logic [ADDR_BITS-1:0] vec);
      logic [1:0] kind;
      unique case (vec)
         VEC_RESET: kind = KIND_RESET;
         VEC_NMI:   kind = KIND_NMI;
         VEC_IRQ:   kind = KIND_IRQ;
         default:   kind = KIND_NONE;
      endcase
      return kind;
   endfunction

endpackage

`default_nettype wire

### rtl/btrb_ctrl.sv
// Sequencing state machine of the branch trace ring buffer.
// Depends on btrb_pkg; drives btrb_datapath through ctrl_cmd_type.
`default_nettype none

module btrb_ctrl
   import btrb_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire logic [1:0]    req_cmd,
   output logic               req_ready,
   input  wire dp_status_type status,
   output ctrl_cmd_type       cmd
);

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign accept = req_valid && (state_ff == ST_IDLE);

   // state register, reset starts with a sweep of the memory
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (req_cmd)
                  CMD_RECORD: if (status.trace_enable) state_in = ST_RECORD;
                  CMD_READ:   state_in = ST_REDUCE;
                  CMD_CLEAR:  state_in = ST_CLEAR;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_RECORD: state_in = ST_IDLE;
         ST_REDUCE: begin
            if (status.slot_in_range) state_in = ST_FETCH;
         end
         ST_FETCH: state_in = ST_RESPOND;
         ST_RESPOND: begin
            if (status.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: cmd.clear_step = 1'b1;
         ST_IDLE: begin
            req_ready       = 1'b1;
            cmd.capture     = accept;
            cmd.clear_start = accept && (req_cmd == CMD_CLEAR);
         end
         ST_RECORD: cmd.record = 1'b1;
         ST_REDUCE: cmd.reduce = !status.slot_in_range;
         ST_FETCH:  cmd.fetch = 1'b1;
         ST_RESPOND: cmd.load_rsp = status.rsp_free;
         default: cmd = '0;
      endcase
   end

endmodule

`default_nettype wire

### rtl/btrb_datapath.sv
// Datapath of the branch trace ring buffer: trace memory, write pointer,
// newest-entry cache, slot arithmetic and response register. Uses btrb_pkg.
`default_nettype none

module btrb_datapath
   import btrb_pkg::*;
#(
   parameter int TRACE_DEPTH = TRACE_DEPTH_DEFAULT
)(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ctrl_cmd_type          cmd,
   output dp_status_type              status,
   input  wire logic                  csr_wr_en,
   input  wire logic                  csr_wr_data,
   input  wire logic [ADDR_BITS-1:0]  req_from_addr,
   input  wire logic [ADDR_BITS-1:0]  req_to_addr,
   input  wire logic [ADDR_BITS-1:0]  req_vector_addr,
   input  wire logic [POS_BITS-1:0]   req_position,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic                       rsp_entry_valid,
   output logic [ADDR_BITS-1:0]       rsp_out_from,
   output logic [ADDR_BITS-1:0]       rsp_out_to,
   output logic [1:0]                 rsp_vector_kind,
   output logic [COUNT_BITS-1:0]      rsp_repeat_count
);

   localparam int IDX_W = $clog2(TRACE_DEPTH);
   localparam int SUM_W = ((IDX_W > POS_BITS) ? IDX_W : POS_BITS) + 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TRACE_DEPTH - 1);
   localparam logic [SUM_W-1:0] DEPTH_S  = SUM_W'(TRACE_DEPTH);

   // trace memory
   entry_type mem [TRACE_DEPTH];

   logic                  enable_ff;
   logic [IDX_W-1:0]      wp_ff;
   logic [IDX_W-1:0]      clr_cnt_ff;
   logic [SUM_W-1:0]      slot_ff;
   logic [ADDR_BITS-1:0]  item_from_ff;
   logic [ADDR_BITS-1:0]  item_to_ff;
   logic [ADDR_BITS-1:0]  item_vec_ff;
   logic                  cache_valid_ff;
   logic [ADDR_BITS-1:0]  cache_from_ff;
   logic [ADDR_BITS-1:0]  cache_to_ff;
   logic [ADDR_BITS-1:0]  cache_vec_ff;
   logic [COUNT_BITS-1:0] cache_count_ff;
   entry_type             rd_data_ff;
   logic                  rsp_valid_ff;
   entry_type             rsp_data_ff;

   logic                  merge;
   logic [IDX_W-1:0]      prev_idx;
   logic [IDX_W-1:0]      wp_next;
   logic [COUNT_BITS-1:0] count_inc;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   entry_type             wr_data;

   // newest entry matches and is not saturated
   assign merge = cache_valid_ff && (cache_from_ff == item_from_ff) &&
                  (cache_to_ff == item_to_ff) && (cache_vec_ff == item_vec_ff) &&
                  (cache_count_ff != COUNT_MAX);
   assign prev_idx  = (wp_ff == '0) ? LAST_IDX : wp_ff - IDX_W'(1);
   assign wp_next   = (wp_ff == LAST_IDX) ? '0 : wp_ff + IDX_W'(1);
   assign count_inc = cache_count_ff + COUNT_BITS'(1);

   // memory write port: clearing sweep or branch record
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = wp_ff;
      wr_data = '0;
      if (cmd.clear_step) begin
         wr_en   = 1'b1;
         wr_addr = clr_cnt_ff;
      end else if (cmd.record) begin
         wr_en = 1'b1;
         if (merge) begin
            wr_addr = prev_idx;
            wr_data = '{valid: 1'b1, from_addr: cache_from_ff, to_addr: cache_to_ff,
                        vector_addr: cache_vec_ff, count: count_inc};
         end else begin
            wr_addr = wp_ff;
            wr_data = '{valid: 1'b1, from_addr: item_from_ff, to_addr: item_to_ff,
                        vector_addr: item_vec_ff, count: COUNT_BITS'(1)};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered memory read
   always_ff @(posedge clock) begin
      if (cmd.fetch) begin
         rd_data_ff <= mem[slot_ff[IDX_W-1:0]];
      end
   end

   // control registers: enable, pointer, sweep counter, cache valid
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff      <= 1'b0;
         wp_ff          <= '0;
         clr_cnt_ff     <= '0;
         cache_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) enable_ff <= csr_wr_data;
         if (cmd.clear_start) begin
            wp_ff          <= '0;
            cache_valid_ff <= 1'b0;
         end else if (cmd.record && !merge) begin
            wp_ff          <= wp_next;
            cache_valid_ff <= 1'b1;
         end
         if (cmd.clear_step) begin
            clr_cnt_ff <= (clr_cnt_ff == LAST_IDX) ? '0 : clr_cnt_ff + IDX_W'(1);
         end
      end
   end

   // newest-entry cache payload
   always_ff @(posedge clock) begin
      if (cmd.record) begin
         if (merge) begin
            cache_count_ff <= count_inc;
         end else begin
            cache_from_ff  <= item_from_ff;
            cache_to_ff    <= item_to_ff;
            cache_vec_ff   <= item_vec_ff;
            cache_count_ff <= COUNT_BITS'(1);
         end
      end
   end

   // item latch and slot number, wrapped one depth per cycle
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_from_ff <= req_from_addr;
         item_to_ff   <= req_to_addr;
         item_vec_ff  <= req_vector_addr;
         slot_ff      <= SUM_W'(wp_ff) + SUM_W'(req_position);
      end else if (cmd.reduce) begin
         slot_ff <= slot_ff - DEPTH_S;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_data_ff <= rd_data_ff.valid ? rd_data_ff : '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_entry_valid  = rsp_data_ff.valid;
   assign rsp_out_from     = rsp_data_ff.from_addr;
   assign rsp_out_to       = rsp_data_ff.to_addr;
   assign rsp_vector_kind  = decode_vector(rsp_data_ff.vector_addr);
   assign rsp_repeat_count = rsp_data_ff.count;

   // status to the controller
   assign status.trace_enable  = enable_ff;
   assign status.slot_in_range = (slot_ff < DEPTH_S);
   assign status.clear_last    = (clr_cnt_ff == LAST_IDX);
   assign status.rsp_free      = !rsp_valid_ff || rsp_ready;

endmodule

`default_nettype wire

### rtl/branch_trace_ring_buffer.sv
// Top level of the branch trace ring buffer with run-length counting.
// Depends on btrb_pkg, btrb_ctrl and btrb_datapath.
//
//   channel   ports                      direction  transfer
//   request   req_valid / req_ready      in         record, read or clear item
//   response  rsp_valid / rsp_ready      out        one item per read
//   csr       csr_wr_en / csr_wr_data    in         trace_enable, no wait
//
// One item at a time through the controller: a record passes the record state
// (it stays idle when tracing is off, as for an unused code), a read stays in
// reduce while TRACE_DEPTH is taken off the slot number write pointer + position,
// then passes fetch and respond, a clear sweeps one memory row per cycle.
// After reset the memory is swept before req_ready rises.
// A held response stalls only a read in its last state; other items still
// enter while the response register waits.
`default_nettype none

module branch_trace_ring_buffer
   import btrb_pkg::*;
#(
   parameter int TRACE_DEPTH = TRACE_DEPTH_DEFAULT
)(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [1:0]            req_cmd,
   input  wire logic [ADDR_BITS-1:0]  req_from_addr,
   input  wire logic [ADDR_BITS-1:0]  req_to_addr,
   input  wire logic [ADDR_BITS-1:0]  req_vector_addr,
   input  wire logic [POS_BITS-1:0]   req_position,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic                       rsp_entry_valid,
   output logic [ADDR_BITS-1:0]       rsp_out_from,
   output logic [ADDR_BITS-1:0]       rsp_out_to,
   output logic [1:0]                 rsp_vector_kind,
   output logic [COUNT_BITS-1:0]      rsp_repeat_count,
   input  wire logic                  csr_wr_en,
   input  wire logic                  csr_wr_data
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // sequencing
   btrb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // storage and arithmetic
   btrb_datapath #(
      .TRACE_DEPTH (TRACE_DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_from_addr    (req_from_addr),
      .req_to_addr      (req_to_addr),
      .req_vector_addr  (req_vector_addr),
      .req_position     (req_position),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_entry_valid  (rsp_entry_valid),
      .rsp_out_from     (rsp_out_from),
      .rsp_out_to       (rsp_out_to),
      .rsp_vector_kind  (rsp_vector_kind),
      .rsp_repeat_count (rsp_repeat_count)
   );

endmodule

`default_nettype wire

### dv/branch_trace_checker.sv
// Scoreboard for the branch trace ring buffer: watches the item channels and the csr port,
// keeps its own copy of the ring and compares every read response field by field.
// Depends on btrb_pkg for widths, command codes, vector addresses and kind codes.
`timescale 1ns / 100ps

module branch_trace_checker
   import btrb_pkg::*;
#(
   parameter int DEPTH = TRACE_DEPTH_DEFAULT
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [1:0]            req_cmd,
   input  logic [ADDR_BITS-1:0]  req_from_addr,
   input  logic [ADDR_BITS-1:0]  req_to_addr,
   input  logic [ADDR_BITS-1:0]  req_vector_addr,
   input  logic [POS_BITS-1:0]   req_position,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic                  rsp_entry_valid,
   input  logic [ADDR_BITS-1:0]  rsp_out_from,
   input  logic [ADDR_BITS-1:0]  rsp_out_to,
   input  logic [1:0]            rsp_vector_kind,
   input  logic [COUNT_BITS-1:0] rsp_repeat_count,
   input  logic                  csr_wr_en,
   input  logic                  csr_wr_data,
   output int                    mismatch_count,
   output int                    pending_reads
);

   localparam int SHOWN_MISMATCHES = 10;

   // one read response as the port presents it
   typedef struct packed {
      logic                  valid;
      logic [ADDR_BITS-1:0]  from_addr;
      logic [ADDR_BITS-1:0]  to_addr;
      logic [1:0]            kind;
      logic [COUNT_BITS-1:0] count;
   } readout_type;

   entry_type   ring [DEPTH];
   int          head;
   logic        tracing;
   readout_type readout_queue [$];

   // empty every slot and rewind the write pointer
   function automatic void wipe_ring();
      for (int i = 0; i < DEPTH; i++) ring[i] = '0;
      head = 0;
   endfunction

   // map an interrupt vector address onto its kind code
   function automatic logic [1:0] vector_class(input logic [ADDR_BITS-1:0] vec);
      if (vec == VEC_RESET) return KIND_RESET;
      else if (vec == VEC_NMI) return KIND_NMI;
      else if (vec == VEC_IRQ) return KIND_IRQ;
      return KIND_NONE;
   endfunction

   // fold a repeat into the newest entry, else append a fresh one
   function automatic void log_branch(input logic [ADDR_BITS-1:0] from_addr,
                                      input logic [ADDR_BITS-1:0] to_addr,
                                      input logic [ADDR_BITS-1:0] vec);
      int newest;
      newest = (head + DEPTH - 1) % DEPTH;
      if (ring[newest].valid && ring[newest].from_addr == from_addr &&
          ring[newest].to_addr == to_addr && ring[newest].vector_addr == vec &&
          ring[newest].count != COUNT_MAX) begin
         ring[newest].count = ring[newest].count + COUNT_BITS'(1);
      end else begin
         ring[head].valid       = 1'b1;
         ring[head].from_addr   = from_addr;
         ring[head].to_addr     = to_addr;
         ring[head].vector_addr = vec;
         ring[head].count       = COUNT_BITS'(1);
         head = (head + 1) % DEPTH;
      end
   endfunction

   // position counts from the oldest slot, which is the write pointer
   function automatic readout_type read_slot(input logic [POS_BITS-1:0] position);
      readout_type r;
      int          slot;
      slot = (head + int'(position)) % DEPTH;
      r = '0;
      if (ring[slot].valid) begin
         r.valid     = 1'b1;
         r.from_addr = ring[slot].from_addr;
         r.to_addr   = ring[slot].to_addr;
         r.kind      = vector_class(ring[slot].vector_addr);
         r.count     = ring[slot].count;
      end
      return r;
   endfunction

   function automatic void note_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= SHOWN_MISMATCHES)
         $display("[%0t] mismatch: %s", $time, msg);
   endfunction

   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (want !== got)
         note_mismatch($sformatf("%s expected %h, got %h", name, want, got));
   endfunction

   // responses are retired before new requests so a same-edge pair stays in order
   always @(posedge clock) begin : monitor
      readout_type want;
      if (reset) begin
         wipe_ring();
         tracing = 1'b0;
         readout_queue.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (readout_queue.size() == 0) begin
               note_mismatch("read response with no read outstanding");
            end else begin
               want = readout_queue.pop_front();
               compare_field("entry_valid", 32'(want.valid), 32'(rsp_entry_valid));
               compare_field("out_from", 32'(want.from_addr), 32'(rsp_out_from));
               compare_field("out_to", 32'(want.to_addr), 32'(rsp_out_to));
               compare_field("vector_kind", 32'(want.kind), 32'(rsp_vector_kind));
               compare_field("repeat_count", want.count, rsp_repeat_count);
            end
         end
         if (csr_wr_en) tracing = csr_wr_data;
         if (req_valid && req_ready) begin
            case (req_cmd)
               CMD_RECORD: begin
                  if (tracing) log_branch(req_from_addr, req_to_addr, req_vector_addr);
               end
               CMD_READ:  readout_queue = {readout_queue, read_slot(req_position)};
               CMD_CLEAR: wipe_ring();
               default: ;
            endcase
         end
      end
      pending_reads = readout_queue.size();
   end

endmodule

### dv/branch_trace_ring_buffer_test.sv
// Top of the branch trace ring buffer testbench: clock, reset, item stimulus, receiver
// stalls, csr writes, watchdog and verdict. Depends on btrb_pkg, the block and
// branch_trace_checker.
`timescale 1ns / 100ps

module branch_trace_ring_buffer_test;
   import btrb_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam int DRAIN_SETTLE   = 80;
   localparam int HOLD_CYCLES    = 250;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int RANDOM_ITEMS   = 1200;
   localparam int PHASE_ITEMS    = 200;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [1:0]            req_cmd;
   logic [ADDR_BITS-1:0]  req_from_addr;
   logic [ADDR_BITS-1:0]  req_to_addr;
   logic [ADDR_BITS-1:0]  req_vector_addr;
   logic [POS_BITS-1:0]   req_position;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_entry_valid;
   logic [ADDR_BITS-1:0]  rsp_out_from;
   logic [ADDR_BITS-1:0]  rsp_out_to;
   logic [1:0]            rsp_vector_kind;
   logic [COUNT_BITS-1:0] rsp_repeat_count;
   logic                  csr_wr_en;
   logic                  csr_wr_data;

   int mismatch_count;
   int pending_reads;

   // stimulus control shared with the receiver process
   bit steady;
   bit hold_req;

   // current run of repeated branches
   logic [ADDR_BITS-1:0] run_from;
   logic [ADDR_BITS-1:0] run_to;
   logic [ADDR_BITS-1:0] run_vector;
   int                   run_left;

   branch_trace_ring_buffer u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_from_addr    (req_from_addr),
      .req_to_addr      (req_to_addr),
      .req_vector_addr  (req_vector_addr),
      .req_position     (req_position),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_entry_valid  (rsp_entry_valid),
      .rsp_out_from     (rsp_out_from),
      .rsp_out_to       (rsp_out_to),
      .rsp_vector_kind  (rsp_vector_kind),
      .rsp_repeat_count (rsp_repeat_count),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   branch_trace_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_from_addr    (req_from_addr),
      .req_to_addr      (req_to_addr),
      .req_vector_addr  (req_vector_addr),
      .req_position     (req_position),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_entry_valid  (rsp_entry_valid),
      .rsp_out_from     (rsp_out_from),
      .rsp_out_to       (rsp_out_to),
      .rsp_vector_kind  (rsp_vector_kind),
      .rsp_repeat_count (rsp_repeat_count),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .mismatch_count   (mismatch_count),
      .pending_reads    (pending_reads)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // receiver: random stalls, one long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_req = 1'b0;
         end
         rsp_ready <= steady || ($urandom_range(99) >= 15);
      end
   end

   // watchdog on cycles where no item moves on either channel
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   // offer one item after an optional gap and hold it until accepted
   task automatic send_item(input logic [1:0] cmd, input logic [ADDR_BITS-1:0] from_addr,
                            input logic [ADDR_BITS-1:0] to_addr,
                            input logic [ADDR_BITS-1:0] vec,
                            input logic [POS_BITS-1:0] position);
      int gap;
      gap = 0;
      if (!steady && $urandom_range(99) < 15) gap = $urandom_range(1, 6);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_from_addr   <= from_addr;
      req_to_addr     <= to_addr;
      req_vector_addr <= vec;
      req_position    <= position;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // stop offering, wait for every read response, then let a clear finish
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_reads != 0) @(negedge clock);
      repeat (DRAIN_SETTLE) @(negedge clock);
   endtask

   task automatic set_tracing(input bit on);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= on;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [ADDR_BITS-1:0] rand_addr();
      return ADDR_BITS'($urandom);
   endfunction

   function automatic logic [POS_BITS-1:0] rand_pos();
      return POS_BITS'($urandom_range(63));
   endfunction

   // small pool of addresses so that runs and near-misses are common
   function automatic logic [ADDR_BITS-1:0] pick_addr();
      case ($urandom_range(7))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'h8000;
         3:       return 16'h1234;
         default: return rand_addr();
      endcase
   endfunction

   function automatic logic [ADDR_BITS-1:0] pick_vector();
      case ($urandom_range(9))
         4:       return VEC_RESET;
         5:       return VEC_NMI;
         6:       return VEC_IRQ;
         7:       return 16'hFFFF;
         8:       return rand_addr();
         default: return 16'h0000;
      endcase
   endfunction

   // mostly runs of repeated branches, with reads, rare clears and unused codes
   task automatic send_random();
      int pick;
      pick = $urandom_range(99);
      if (pick < 55) begin
         if (run_left == 0) begin
            run_from   = pick_addr();
            run_to     = pick_addr();
            run_vector = pick_vector();
            run_left   = $urandom_range(1, 6);
         end
         run_left--;
         send_item(CMD_RECORD, run_from, run_to, run_vector, rand_pos());
      end else if (pick < 94) begin
         send_item(CMD_READ, rand_addr(), rand_addr(), rand_addr(), rand_pos());
      end else if (pick < 96) begin
         send_item(CMD_CLEAR, rand_addr(), rand_addr(), rand_addr(), rand_pos());
      end else begin
         send_item(CMD_UNUSED, rand_addr(), rand_addr(), rand_addr(), rand_pos());
      end
   endtask

   initial begin
      int sent;
      int in_phase;
      int phase;

      reset           = 1'b1;
      req_valid       = 1'b0;
      req_cmd         = CMD_RECORD;
      req_from_addr   = '0;
      req_to_addr     = '0;
      req_vector_addr = '0;
      req_position    = '0;
      csr_wr_en       = 1'b0;
      csr_wr_data     = 1'b0;
      steady          = 1'b0;
      hold_req        = 1'b0;
      run_left        = 0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // tracing off after reset: records dropped, ring reads empty
      send_item(CMD_RECORD, 16'h1111, 16'h2222, 16'h0000, 6'd0);
      send_item(CMD_READ, 16'h0000, 16'h0000, 16'h0000, 6'd0);
      send_item(CMD_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd63);
      send_item(CMD_READ, 16'h0000, 16'h0000, 16'h0000, 6'd63);
      drain();
      set_tracing(1'b1);

      // repeat merge, every vector kind, vector-only difference, older repeat
      send_item(CMD_RECORD, 16'h0000, 16'h0000, 16'h0000, 6'd0);
      send_item(CMD_RECORD, 16'h0000, 16'h0000, 16'h0000, 6'd63);
      send_item(CMD_RECORD, 16'hFFFF, 16'hFFFF, VEC_RESET, 6'd0);
      send_item(CMD_RECORD, 16'h8001, 16'h7FFE, VEC_NMI, 6'd0);
      send_item(CMD_RECORD, 16'h00FF, 16'hFF00, VEC_IRQ, 6'd0);
      send_item(CMD_RECORD, 16'h1234, 16'h4321, 16'h1234, 6'd0);
      send_item(CMD_RECORD, 16'h1234, 16'h4321, 16'hFFFF, 6'd0);
      send_item(CMD_RECORD, 16'hFFFF, 16'hFFFF, VEC_RESET, 6'd0);
      for (int p = 57; p < 64; p++)
         send_item(CMD_READ, 16'h0000, 16'h0000, 16'h0000, POS_BITS'(p));
      send_item(CMD_READ, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd0);

      // clear empties the ring, tracing off keeps what is there
      send_item(CMD_CLEAR, 16'h0000, 16'h0000, 16'h0000, 6'd0);
      send_item(CMD_READ, 16'h0000, 16'h0000, 16'h0000, 6'd63);
      send_item(CMD_RECORD, 16'hABCD, 16'h5432, VEC_IRQ, 6'd0);
      drain();
      set_tracing(1'b0);
      send_item(CMD_RECORD, 16'h2468, 16'h1357, 16'h0000, 6'd0);
      send_item(CMD_READ, 16'h0000, 16'h0000, 16'h0000, 6'd63);

      // random phases: tracing toggles, one long receiver hold-off, one stall-free stretch
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         drain();
         set_tracing(phase % 4 != 2);
         steady = (phase == 3);
         if (phase == 1) hold_req = 1'b1;
         in_phase = 0;
         while (in_phase < PHASE_ITEMS && sent < RANDOM_ITEMS) begin
            send_random();
            in_phase++;
            sent++;
         end
         phase++;
      end

      steady = 1'b0;
      drain();
      if (mismatch_count == 0 && pending_reads == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/btrb_pkg.sv
rtl/btrb_ctrl.sv
rtl/btrb_datapath.sv
rtl/branch_trace_ring_buffer.sv
dv/branch_trace_checker.sv
dv/branch_trace_ring_buffer_test.sv
